### design/weo_pkg.sv
// ----------------------------------------------------------------------------
// weo_pkg
// Shared types, constants and helpers for the wheel encoder odometry block.
// ----------------------------------------------------------------------------
package weo_pkg;

	localparam int ATAN_LEN = 24;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [29:0] ANGLE_PER_RAD = 30'd683565276;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul1;
		logic sat;
		logic mul2;
		logic turn;
		logic mul3;
		logic init;
		logic step;
		logic fix;
		logic mpos;
		logic commit;
		logic [4:0] idx;
	} cmd_t;

	// atan(2^-i) as a binary angle, Q0.32 turn scale (2^32 per turn)
	function automatic logic [29:0] atan_at(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0: a = 30'h20000000;
			5'd1: a = 30'h12E4051E;
			5'd2: a = 30'h09FB385B;
			5'd3: a = 30'h051111D4;
			5'd4: a = 30'h028B0D43;
			5'd5: a = 30'h0145D7E1;
			5'd6: a = 30'h00A2F61E;
			5'd7: a = 30'h00517C55;
			5'd8: a = 30'h0028BE53;
			5'd9: a = 30'h00145F2F;
			5'd10: a = 30'h000A2F98;
			5'd11: a = 30'h000517CC;
			5'd12: a = 30'h00028BE6;
			5'd13: a = 30'h000145F3;
			5'd14: a = 30'h0000A2FA;
			5'd15: a = 30'h0000517D;
			5'd16: a = 30'h000028BE;
			5'd17: a = 30'h0000145F;
			5'd18: a = 30'h00000A30;
			5'd19: a = 30'h00000518;
			5'd20: a = 30'h0000028C;
			5'd21: a = 30'h00000146;
			5'd22: a = 30'h000000A3;
			5'd23: a = 30'h00000051;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// signed result from sign and 48-bit magnitude, saturated to 32 bits
	function automatic logic [31:0] sat_mag48(input logic neg, input logic [47:0] m);
		logic [31:0] r;
		if (!neg)
			r = (|m[47:31]) ? 32'h7FFFFFFF : m[31:0];
		else
			r = (m > 48'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
		return r;
	endfunction

	function automatic logic [31:0] sat37(input logic [36:0] v);
		logic [31:0] r;
		if ((&v[36:31]) || !(|v[36:31]))
			r = v[31:0];
		else
			r = v[36] ? 32'h80000000 : 32'h7FFFFFFF;
		return r;
	endfunction

endpackage

### design/weo_div.sv
// ----------------------------------------------------------------------------
// weo_div
// Radix-2 restoring divider: dividend / 24-bit divisor, signed 32-bit saturated
// quotient, one bit per step over 32 steps.
// ----------------------------------------------------------------------------
module weo_div (
	input  logic        clk,
	input  logic        init,
	input  logic        step,
	input  logic [67:0] dividend,
	input  logic        neg,
	input  logic [23:0] divisor,
	output logic [31:0] quotient
);

	logic [23:0] rem_q;
	logic [31:0] sh_q;
	logic ovf_q;
	logic neg_q;
	logic [24:0] r2;
	logic fits;

	assign r2 = {rem_q, sh_q[31]};
	assign fits = r2 >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (init) begin
			ovf_q <= dividend[67:32] >= {12'b0, divisor};
			rem_q <= dividend[55:32];
			sh_q <= dividend[31:0];
			neg_q <= neg;
		end else if (step) begin
			rem_q <= fits ? 24'(r2 - {1'b0, divisor}) : r2[23:0];
			sh_q <= {sh_q[30:0], fits};
		end
	end

	always_comb begin
		if (neg_q)
			quotient = (ovf_q || sh_q[31]) ? 32'h80000000 : (~sh_q + 32'd1);
		else
			quotient = (ovf_q || sh_q[31]) ? 32'h7FFFFFFF : sh_q;
	end

endmodule

### design/weo_dp.sv
// ----------------------------------------------------------------------------
// weo_dp
// Odometry datapath: distance scaling, turn, heading update, shared CORDIC,
// velocity dividers and saturating position update.
// ----------------------------------------------------------------------------
module weo_dp #(
	parameter int STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  weo_pkg::cmd_t  cmd,
	input  logic [31:0]    meters_per_tick,
	input  logic [31:0]    inverse_track_width,
	input  logic [31:0]    left_count,
	input  logic [31:0]    right_count,
	input  logic [23:0]    elapsed_us,
	output logic [31:0]    pos_x,
	output logic [31:0]    pos_y,
	output logic [15:0]    heading,
	output logic [31:0]    linear_velocity,
	output logic [31:0]    angular_velocity,
	output logic           velocity_valid
);

	logic [31:0] prev_l_q, prev_r_q, pos_x_q, pos_y_q, head_q;
	logic [31:0] dl_q, dr_q;
	logic [23:0] us_q;
	logic [63:0] pl_q, pr_q;
	logic sl_q, sr_q;
	logic [31:0] distl_q, distr_q;
	logic [31:0] travel_q;
	logic [32:0] diff_q;
	logic [63:0] tp_q;
	logic tneg_q;
	logic [53:0] hlo_q, hhi_q;
	logic [67:0] nl_q, na_q;
	logic [31:0] hdelta_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic flip_q;
	logic signed [65:0] px_q, py_q;
	logic [31:0] lin_div, ang_div;

	logic [32:0] dsum;
	logic [32:0] dmag;
	logic [47:0] tmag;
	logic [47:0] hsum, hneg;
	logic [31:0] fold;
	logic do_step;
	logic signed [33:0] xs, ys, at;
	logic [36:0] nx, ny;

	assign dsum = {distl_q[31], distl_q} + {distr_q[31], distr_q};
	assign dmag = diff_q[32] ? (~diff_q + 33'd1) : diff_q;
	assign tmag = tp_q[63:16];
	assign hsum = hlo_q[47:0] + {hhi_q[23:0], 24'b0};
	assign hneg = tneg_q ? (~hsum + 48'd1) : hsum;
	// fold heading into [-pi/2, pi/2) by a half turn
	assign fold = (head_q[31] ^ head_q[30]) ? (head_q ^ 32'h80000000) : head_q;
	assign do_step = cmd.step && ({27'b0, cmd.idx} < 32'(STEPS));
	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;
	assign at = {4'b0, weo_pkg::atan_at(cmd.idx)};
	assign nx = {pos_x_q[31], pos_x_q[31], pos_x_q[31], pos_x_q[31], pos_x_q[31], pos_x_q}
		+ {px_q[65], px_q[65:30]};
	assign ny = {pos_y_q[31], pos_y_q[31], pos_y_q[31], pos_y_q[31], pos_y_q[31], pos_y_q}
		+ {py_q[65], py_q[65:30]};

	// odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
		end else begin
			if (cmd.load) begin
				prev_l_q <= left_count;
				prev_r_q <= right_count;
			end
			if (cmd.commit) begin
				pos_x_q <= weo_pkg::sat37(nx);
				pos_y_q <= weo_pkg::sat37(ny);
				head_q <= head_q + hdelta_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dl_q <= left_count - prev_l_q;
			dr_q <= right_count - prev_r_q;
			us_q <= elapsed_us;
		end
		if (cmd.mul1) begin
			pl_q <= {32'b0, weo_pkg::mag32(dl_q)} * {32'b0, meters_per_tick};
			pr_q <= {32'b0, weo_pkg::mag32(dr_q)} * {32'b0, meters_per_tick};
			sl_q <= dl_q[31];
			sr_q <= dr_q[31];
		end
		if (cmd.sat) begin
			distl_q <= weo_pkg::sat_mag48(sl_q, pl_q[63:16]);
			distr_q <= weo_pkg::sat_mag48(sr_q, pr_q[63:16]);
		end
		if (cmd.mul2) begin
			travel_q <= dsum[32:1];
			diff_q <= {distr_q[31], distr_q} - {distl_q[31], distl_q};
		end
		if (cmd.turn) begin
			tp_q <= 64'({31'b0, dmag} * {32'b0, inverse_track_width});
			tneg_q <= diff_q[32];
		end
		if (cmd.mul3) begin
			hlo_q <= {30'b0, tmag[23:0]} * {24'b0, weo_pkg::ANGLE_PER_RAD};
			hhi_q <= {30'b0, tmag[47:24]} * {24'b0, weo_pkg::ANGLE_PER_RAD};
			nl_q <= {36'b0, weo_pkg::mag32(travel_q)} * {48'b0, weo_pkg::USEC_PER_SEC};
			na_q <= {20'b0, tmag} * {48'b0, weo_pkg::USEC_PER_SEC};
		end
		if (cmd.init) begin
			x_q <= weo_pkg::CORDIC_X0;
			y_q <= '0;
			z_q <= {{2{fold[31]}}, fold};
			flip_q <= head_q[31] ^ head_q[30];
		end else if (do_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end else if (cmd.fix && flip_q) begin
			x_q <= -x_q;
			y_q <= -y_q;
		end
		if (cmd.fix)
			hdelta_q <= hneg[47:16];
		if (cmd.mpos) begin
			px_q <= $signed({{34{travel_q[31]}}, travel_q}) * $signed({{32{x_q[33]}}, x_q});
			py_q <= $signed({{34{travel_q[31]}}, travel_q}) * $signed({{32{y_q[33]}}, y_q});
		end
		if (cmd.commit) begin
			pos_x <= weo_pkg::sat37(nx);
			pos_y <= weo_pkg::sat37(ny);
			heading <= 16'((head_q + hdelta_q) >> 16);
			linear_velocity <= (us_q == 24'd0) ? 32'd0 : lin_div;
			angular_velocity <= (us_q == 24'd0) ? 32'd0 : ang_div;
			velocity_valid <= us_q != 24'd0;
		end
	end

	weo_div u_div_lin (
		.clk      (clk),
		.init     (cmd.init),
		.step     (cmd.step),
		.dividend (nl_q),
		.neg      (travel_q[31]),
		.divisor  (us_q),
		.quotient (lin_div)
	);

	weo_div u_div_ang (
		.clk      (clk),
		.init     (cmd.init),
		.step     (cmd.step),
		.dividend (na_q),
		.neg      (tneg_q),
		.divisor  (us_q),
		.quotient (ang_div)
	);

endmodule

### design/weo_ctrl.sv
// ----------------------------------------------------------------------------
// weo_ctrl
// Sequencer for one odometry word: multiply and scale steps, a shared
// iteration phase, position commit, output word handshake.
// ----------------------------------------------------------------------------
module weo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output weo_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_SAT  = 4'd2;
	localparam logic [3:0] ST_MUL2 = 4'd3;
	localparam logic [3:0] ST_TURN = 4'd4;
	localparam logic [3:0] ST_MUL3 = 4'd5;
	localparam logic [3:0] ST_INIT = 4'd6;
	localparam logic [3:0] ST_RUN  = 4'd7;
	localparam logic [3:0] ST_FIX  = 4'd8;
	localparam logic [3:0] ST_MPOS = 4'd9;
	localparam logic [3:0] ST_ADD  = 4'd10;

	logic [3:0] state_q, state_d;
	logic [4:0] idx_q;
	logic oval_q;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = oval_q;

	always_comb begin
		cmd = '0;
		cmd.load = s_tvalid && (state_q == ST_IDLE);
		cmd.mul1 = state_q == ST_MUL1;
		cmd.sat = state_q == ST_SAT;
		cmd.mul2 = state_q == ST_MUL2;
		cmd.turn = state_q == ST_TURN;
		cmd.mul3 = state_q == ST_MUL3;
		cmd.init = state_q == ST_INIT;
		cmd.step = state_q == ST_RUN;
		cmd.fix = state_q == ST_FIX;
		cmd.mpos = state_q == ST_MPOS;
		// output slot must be free before the word is committed
		cmd.commit = (state_q == ST_ADD) && (!oval_q || m_tready);
		cmd.idx = idx_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL1;
			ST_MUL1: state_d = ST_SAT;
			ST_SAT:  state_d = ST_MUL2;
			ST_MUL2: state_d = ST_TURN;
			ST_TURN: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_INIT;
			ST_INIT: state_d = ST_RUN;
			ST_RUN:  if (idx_q == 5'd31) state_d = ST_FIX;
			ST_FIX:  state_d = ST_MPOS;
			ST_MPOS: state_d = ST_ADD;
			ST_ADD:  if (!oval_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			oval_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= (state_q == ST_RUN) ? idx_q + 5'd1 : 5'd0;
			if (cmd.commit)
				oval_q <= 1'b1;
			else if (m_tready)
				oval_q <= 1'b0;
		end
	end

endmodule

### design/wheel_encoder_odometry.sv
// The 32-step velocity dividers set the iteration phase, with the CORDIC run
// alongside them; a new input word is taken only after the last is committed.
// The next input word is taken while a finished word waits at the output.
// Reset clears counts, position and heading and restores register defaults.
// ----------------------------------------------------------------------------
// wheel_encoder_odometry
// Differential drive odometry from wheel encoder counts, with APB registers.
// ----------------------------------------------------------------------------
module wheel_encoder_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // left_count, right_count, elapsed_us
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // pos_x, pos_y, heading, linear_velocity,
	                                // angular_velocity
	output logic [0:0]   m_tuser,   // velocity_valid
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int NSTEP = (CORDIC_STEPS > weo_pkg::ATAN_LEN) ? weo_pkg::ATAN_LEN
		: CORDIC_STEPS;

	logic [31:0] mpt_q, itw_q;
	weo_pkg::cmd_t cmd;
	logic [31:0] pos_x, pos_y, lin, ang;
	logic [15:0] heading;
	logic vvalid;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? itw_q : mpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q <= 32'd3747367;
			itw_q <= 32'd198596;
		end else if (psel && penable && pwrite) begin
			if (paddr[2])
				itw_q <= pwdata;
			else
				mpt_q <= pwdata;
		end
	end

	weo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	weo_dp #(
		.STEPS (NSTEP)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.meters_per_tick     (mpt_q),
		.inverse_track_width (itw_q),
		.left_count          (s_tdata[31:0]),
		.right_count         (s_tdata[63:32]),
		.elapsed_us          (s_tdata[87:64]),
		.pos_x               (pos_x),
		.pos_y               (pos_y),
		.heading             (heading),
		.linear_velocity     (lin),
		.angular_velocity    (ang),
		.velocity_valid      (vvalid)
	);

	assign m_tdata = {ang, lin, heading, pos_y, pos_x};
	assign m_tuser = vvalid;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives encoder count words into the odometry block and checks every output
// word against a cycle-free predictor of pose and velocity, across several
// register settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam logic [2:0] REG_MPT = 3'd0;
	localparam logic [2:0] REG_ITW = 3'd4;
	localparam longint LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] hd;
		logic [31:0] lin;
		logic [31:0] ang;
		logic vv;
	} pose_t;

	typedef struct {
		logic [31:0] l;
		logic [31:0] r;
		logic [23:0] us;
		bit fixed;      // expectation typed in
		logic [31:0] ex_x;
		logic [15:0] ex_hd;
		logic ex_vv;
	} stim_t;

	pose_t pose_q[$];
	int errors = 0;
	longint cycles = 0;
	int words_out = 0;

	logic [31:0] mpt, itw, prev_l, prev_r, hd_angle;
	logic signed [31:0] px, py;

	wheel_encoder_odometry #(.CORDIC_STEPS(STEPS)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint sat_32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_q16(longint a, logic [31:0] b);
		longint unsigned m, r;
		m = a < 0 ? -a : a;
		r = m * b[31:16] + ((m * b[15:0]) >> 16);
		return a < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] rate(longint a, logic [23:0] us);
		longint unsigned m, q;
		m = a < 0 ? -a : a;
		if (us == 0) return 32'd0;
		// product beyond 64 bits pins the quotient at its top
		if (m > 64'hFFFFFFFFFFFFFFFF / 64'd1000000)
			q = 64'hFFFFFFFFFFFFFFFF;
		else
			q = m * 64'd1000000 / us;
		if (a < 0) return q >= 64'h80000000 ? 32'h80000000 : 32'(-q);
		return q > 64'h7FFFFFFF ? 32'h7FFFFFFF : 32'(q);
	endfunction

	function automatic pose_t advance_pose(logic [31:0] l, logic [31:0] r,
			logic [23:0] us);
		longint dl, dr, trav, trn, z, cx, sy, nx;
		logic [31:0] ang;
		logic [63:0] hprod;
		bit flip;
		pose_t p;
		dl = sat_32(scale_q16(longint'(signed'(l - prev_l)), mpt));
		dr = sat_32(scale_q16(longint'(signed'(r - prev_r)), mpt));
		prev_l = l;
		prev_r = r;
		trav = floor_shr(dl + dr, 1);
		trn = scale_q16(dr - dl, itw);
		ang = hd_angle;
		flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
		if (flip) ang = ang - 32'h80000000;
		z = longint'(signed'(ang));
		cx = 652032874;
		sy = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = cx - floor_shr(sy, i);
				sy = sy + floor_shr(cx, i);
				z -= weo_pkg::atan_at(5'(i));
			end else begin
				nx = cx + floor_shr(sy, i);
				sy = sy - floor_shr(cx, i);
				z += weo_pkg::atan_at(5'(i));
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			sy = -sy;
		end
		px = 32'(sat_32(longint'(px) + floor_shr(trav * cx, 30)));
		py = 32'(sat_32(longint'(py) + floor_shr(trav * sy, 30)));
		hprod = 64'(trn) * 64'd683565276;
		hd_angle = hd_angle + hprod[47:16];
		p.x = px;
		p.y = py;
		p.hd = hd_angle[31:16];
		p.lin = us != 0 ? rate(trav, us) : 0;
		p.ang = us != 0 ? rate(trn, us) : 0;
		p.vv = us != 0;
		return p;
	endfunction

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == REG_MPT) mpt = d;
		else itw = d;
		@(posedge clk);
	endtask

	task automatic send_word(logic [31:0] l, logic [31:0] r, logic [23:0] us);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {us, r, l};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pose_q = {pose_q, advance_pose(l, r, us)};
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// output side: random stalls, compare with oldest expectation
	initial begin
		int stall;
		pose_t e;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			words_out++;
			if (pose_q.size() == 0) begin
				$error("unexpected output word");
				errors++;
			end else begin
				e = pose_q.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$error("pos_x exp %h got %h", e.x, m_tdata[31:0]); errors++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$error("pos_y exp %h got %h", e.y, m_tdata[63:32]); errors++;
				end
				if (m_tdata[79:64] !== e.hd) begin
					$error("heading exp %h got %h", e.hd, m_tdata[79:64]); errors++;
				end
				if (m_tdata[111:80] !== e.lin) begin
					$error("linear_velocity exp %h got %h", e.lin, m_tdata[111:80]);
					errors++;
				end
				if (m_tdata[143:112] !== e.ang) begin
					$error("angular_velocity exp %h got %h", e.ang, m_tdata[143:112]);
					errors++;
				end
				if (m_tuser[0] !== e.vv) begin
					$error("velocity_valid exp %b got %b", e.vv, m_tuser[0]); errors++;
				end
			end
		end
	end

	initial begin
		stim_t dir[11];
		stim_t s;
		logic [31:0] l, r;
		mpt = 3747367;
		itw = 198596;
		{prev_l, prev_r, hd_angle} = '0;
		px = 0;
		py = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir = '{
			// no motion after reset: all zeros, valid clear
			'{0, 0, 0, 1, 0, 0, 0},
			'{0, 0, 1, 1, 0, 0, 1},
			'{1000, 1000, 50000, 0, 0, 0, 0},
			'{1000, 1500, 20000, 0, 0, 0, 0},
			'{2000, 1500, 24'hFFFFFF, 0, 0, 0, 0},
			'{32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, 0, 0, 0},
			// encoder wrap through the sign boundary
			'{32'h80000005, 32'h80000009, 10, 0, 0, 0, 0},
			'{32'hFFFFFFF0, 32'h00000010, 0, 0, 0, 0, 0},
			'{32'h00000010, 32'hFFFFFFF0, 1000, 0, 0, 0, 0},
			'{32'h80000000, 32'h7FFFFFFF, 1, 0, 0, 0, 0},
			'{32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 0, 0, 0, 0}
		};
		foreach (dir[i]) begin
			s = dir[i];
			send_word(s.l, s.r, s.us);
			if (s.fixed) begin
				if (pose_q[$].x !== s.ex_x || pose_q[$].hd !== s.ex_hd ||
						pose_q[$].vv !== s.ex_vv) begin
					$error("predictor disagrees with typed result in row %0d", i);
					errors++;
				end
			end
		end
		drain();

		// register extremes: huge scales saturate distance and velocities
		reg_write(REG_MPT, 32'hFFFFFFFF);
		reg_write(REG_ITW, 32'hFFFFFFFF);
		for (int i = 0; i < 8; i++)
			send_word(prev_l + $urandom_range(0, 100000) - 50000,
				prev_r + $urandom(), 24'($urandom_range(0, 3)));
		drain();
		reg_write(REG_MPT, 32'h0);
		reg_write(REG_ITW, 32'h0);
		for (int i = 0; i < 4; i++) send_word($urandom(), $urandom(), 24'($urandom()));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			reg_write(REG_MPT, ph == 0 ? 32'd3747367 : $urandom_range(0, 32'h03FFFFFF));
			reg_write(REG_ITW, ph == 0 ? 32'd198596 : $urandom_range(0, 32'h003FFFFF));
			for (int i = 0; i < 95; i++) begin
				case ($urandom_range(0, 9))
					0: begin
						l = $urandom();
						r = $urandom();
					end
					1: begin
						l = prev_l + $urandom_range(0, 200000) - 100000;
						r = prev_r - $urandom_range(0, 200000);
					end
					default: begin
						// realistic motion: small, mostly forward deltas
						l = prev_l + $urandom_range(0, 4000) - 1000;
						r = prev_r + $urandom_range(0, 4000) - 1000;
					end
				endcase
				send_word(l, r, 24'($urandom_range(0, 7) == 0 ? $urandom_range(0, 1)
					: ($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(1, 100000))));
			end
			drain();
		end

		$display("Checked %0d output words over directed rows, register extremes and",
			words_out);
		$display("four random phases with mixed motion and noisy encoder counts.");
		if (errors == 0 && pose_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
